### rtl/core/lhp_pkg.sv
// Shared types and constants of the latency histogram profiler.
package lhp_pkg;

    // Configuration register indexes
    localparam logic CFG_BUCKET_WIDTH = 1'b0;
    localparam logic CFG_BUCKET_COUNT = 1'b1;

    // Fixed field widths
    localparam int FIELD_TIME_W = 48;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 320;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_END    = 2'd1,
        OP_MEDIAN = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_ROUND,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_MED_RD,
        ST_MED_ACC,
        ST_SEL_RD,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic begin_wr;
        logic div_init;
        logic div_step;
        logic round;
        logic mem_rd;
        logic mem_inc;
        logic med_init;
        logic med_acc;
        logic sel_init;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic med_stop;
        logic bad_label;
        logic out_free;
        t_op  op;
    } t_sts;

endpackage

### rtl/core/lhp_ctrl.sv
// Sequencing state machine of the latency histogram profiler.
module lhp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  lhp_pkg::t_sts i_sts,
    output logic          o_ready,
    output lhp_pkg::t_cmd o_cmd
);

    lhp_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            lhp_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = lhp_pkg::ST_IDLE;
            end
            lhp_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = lhp_pkg::ST_DISPATCH;
                end
            end
            lhp_pkg::ST_DISPATCH: begin
                if (i_sts.bad_label) begin
                    n_state = lhp_pkg::ST_OUT;
                end else begin
                    case (i_sts.op)
                        lhp_pkg::OP_BEGIN: begin
                            o_cmd.begin_wr = 1'b1;
                            n_state        = lhp_pkg::ST_OUT;
                        end
                        lhp_pkg::OP_END: begin
                            o_cmd.div_init = 1'b1;
                            n_state        = lhp_pkg::ST_DIV;
                        end
                        lhp_pkg::OP_MEDIAN: begin
                            o_cmd.med_init = 1'b1;
                            n_state        = lhp_pkg::ST_MED_RD;
                        end
                        default: begin
                            o_cmd.sel_init = 1'b1;
                            n_state        = lhp_pkg::ST_SEL_RD;
                        end
                    endcase
                end
            end
            lhp_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = lhp_pkg::ST_ROUND;
            end
            lhp_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = lhp_pkg::ST_UPD_RD;
            end
            lhp_pkg::ST_UPD_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = lhp_pkg::ST_UPD_WR;
            end
            lhp_pkg::ST_UPD_WR: begin
                o_cmd.mem_inc = 1'b1;
                n_state       = lhp_pkg::ST_OUT;
            end
            lhp_pkg::ST_MED_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = lhp_pkg::ST_MED_ACC;
            end
            lhp_pkg::ST_MED_ACC: begin
                o_cmd.med_acc = 1'b1;
                n_state = i_sts.med_stop ? lhp_pkg::ST_OUT : lhp_pkg::ST_MED_RD;
            end
            lhp_pkg::ST_SEL_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = lhp_pkg::ST_OUT;
            end
            lhp_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lhp_pkg::ST_IDLE;
                end
            end
            default: n_state = lhp_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/core/lhp_dp.sv
// Datapath of the latency histogram profiler: statistics, divider, bucket memory.
module lhp_dp #(
    parameter int LABELS    = 16,
    parameter int BUCKETS   = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lhp_pkg::t_cmd                   i_cmd,
    output lhp_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic [1:0]                      i_in_user,
    input  logic [lhp_pkg::IN_DATA_W-1:0]   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_out_user,
    output logic [lhp_pkg::OUT_DATA_W-1:0]  o_out_data
);

    localparam int DEPTH = LABELS * BUCKETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (LABELS > 1) ? $clog2(LABELS) : 1;
    localparam int BIW   = $clog2(BUCKETS);
    localparam int NBW   = ($clog2(BUCKETS + 1) > 7) ? $clog2(BUCKETS + 1) : 7;
    localparam int DCW   = $clog2(TIME_BITS);
    localparam int RUNW  = 32 + BIW;
    localparam int TW    = lhp_pkg::FIELD_TIME_W;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [TW-1:0] to_field(input logic [TIME_BITS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[TW-1:0];
    endfunction

    // Configuration
    logic [31:0] r_width;
    logic [6:0]  r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 32'd1;
            r_count <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lhp_pkg::CFG_BUCKET_WIDTH: r_width <= i_cfg_data;
                lhp_pkg::CFG_BUCKET_COUNT: r_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [31:0]    w_eff;
    logic [NBW-1:0] nb_full, nb_m1_full;
    logic [BIW-1:0] nb_m1;
    always_comb begin
        w_eff = (r_width == '0) ? 32'd1 : r_width;
        if (r_count == '0)                         nb_full = NBW'(1);
        else if (NBW'(r_count) > NBW'(BUCKETS))   nb_full = NBW'(BUCKETS);
        else                                       nb_full = NBW'(r_count);
        nb_m1_full = nb_full - NBW'(1);
        nb_m1      = nb_m1_full[BIW-1:0];
    end

    // Captured item
    lhp_pkg::t_op r_op;
    logic [4:0]   r_label;
    logic [47:0]  r_time;
    logic [5:0]   r_sel;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= lhp_pkg::t_op'(i_in_user);
            r_label <= i_in_data[4:0];
            r_time  <= i_in_data[52:5];
            r_sel   <= i_in_data[58:53];
        end
    end

    logic [8:0]           lab_ext;
    logic [LW-1:0]        lab;
    logic                 bad;
    logic [63:0]          time_ext;
    logic [TIME_BITS-1:0] now;
    logic [10:0]          sel_ext;
    logic                 sel_ok;
    always_comb begin
        lab_ext  = {4'd0, r_label};
        lab      = lab_ext[LW-1:0];
        bad      = lab_ext >= 9'(LABELS);
        time_ext = 64'(r_time);
        now      = time_ext[TIME_BITS-1:0];
        sel_ext  = {5'd0, r_sel};
        sel_ok   = sel_ext < 11'(BUCKETS);
    end

    // Per-label statistics
    logic [TIME_BITS-1:0] r_start [LABELS];
    logic [TIME_BITS-1:0] r_min   [LABELS];
    logic [TIME_BITS-1:0] r_max   [LABELS];
    logic [63:0]          r_sum   [LABELS];
    logic [31:0]          r_cnt   [LABELS];
    logic [31:0]          r_ovc   [LABELS];

    // Divider and rounding
    logic [TIME_BITS-1:0] r_d, r_quo;
    logic [31:0]          r_rem;
    logic [DCW-1:0]       r_dcnt;
    logic [BIW-1:0]       r_bidx;
    logic                 r_ovf;
    logic [32:0]          rem_sh;
    logic                 q_bit;
    logic                 up;
    logic [TIME_BITS:0]   q1;
    always_comb begin
        rem_sh = {r_rem, r_quo[TIME_BITS-1]};
        q_bit  = rem_sh >= {1'b0, w_eff};
        up     = {r_rem, 1'b0} >= {1'b0, w_eff};
        q1     = {1'b0, r_quo} + (TIME_BITS + 1)'(up);
    end

    // Median walk
    logic [RUNW-1:0] r_run, run_n;
    logic [BIW-1:0]  r_med;
    logic [31:0]     r_rdata;
    logic            med_hit;
    always_comb begin
        run_n   = r_run + RUNW'(r_rdata);
        med_hit = run_n >= RUNW'(r_cnt[lab] >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_d    <= now - r_start[lab];
            r_quo  <= now - r_start[lab];
            r_rem  <= '0;
            r_dcnt <= DCW'(TIME_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? 32'(rem_sh - {1'b0, w_eff}) : rem_sh[31:0];
            r_quo  <= {r_quo[TIME_BITS-2:0], q_bit};
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.round) begin
            if (q1 < (TIME_BITS + 1)'(nb_m1)) begin
                r_bidx <= q1[BIW-1:0];
                r_ovf  <= 1'b0;
            end else begin
                r_bidx <= nb_m1;
                r_ovf  <= 1'b1;
            end
        end else if (i_cmd.med_init) begin
            r_bidx <= '0;
        end else if (i_cmd.sel_init) begin
            r_bidx <= sel_ext[BIW-1:0];
        end else if (i_cmd.med_acc && !med_hit) begin
            r_bidx <= r_bidx + BIW'(1);
        end
        if (i_cmd.med_init) begin
            r_run <= '0;
            r_med <= '0;
        end else if (i_cmd.med_acc) begin
            r_run <= run_n;
            if (med_hit) r_med <= r_bidx;
        end
    end

    // Statistics update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LABELS; i++) begin
                r_start[i] <= '0;
                r_min[i]   <= '1;
                r_max[i]   <= '0;
                r_sum[i]   <= '0;
                r_cnt[i]   <= '0;
                r_ovc[i]   <= '0;
            end
        end else if (i_cmd.begin_wr) begin
            r_start[lab] <= now;
        end else if (i_cmd.mem_inc) begin
            if (r_d > r_max[lab]) r_max[lab] <= r_d;
            if (r_d < r_min[lab]) r_min[lab] <= r_d;
            r_sum[lab] <= r_sum[lab] + 64'(r_d);
            r_cnt[lab] <= sat_inc(r_cnt[lab]);
            if (r_ovf) r_ovc[lab] <= sat_inc(r_ovc[lab]);
        end
    end

    // Bucket memory with clearing sweep
    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_caddr;
    logic [AW-1:0] addr;
    always_comb addr = AW'(lab * BUCKETS + r_bidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_caddr <= r_caddr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_caddr] <= '0;
        end else if (i_cmd.mem_inc) begin
            r_mem[addr] <= sat_inc(r_rdata);
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    // Result register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic [lhp_pkg::OUT_DATA_W-1:0] n_out_data;
    logic [lhp_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_user;
    logic                           is_end;
    always_comb begin
        n_out_data = '0;
        is_end     = (r_op == lhp_pkg::OP_END);
        if (!bad) begin
            if (is_end) begin
                n_out_data[47:0]  = to_field(r_d);
                n_out_data[53:48] = 6'(r_bidx);
                n_out_data[54]    = r_ovf;
            end
            n_out_data[86:55]   = r_cnt[lab];
            n_out_data[150:87]  = r_sum[lab];
            n_out_data[198:151] = to_field(r_min[lab]);
            n_out_data[246:199] = to_field(r_max[lab]);
            n_out_data[278:247] = r_ovc[lab];
            if (r_op == lhp_pkg::OP_MEDIAN) n_out_data[284:279] = 6'(r_med);
            if (r_op == lhp_pkg::OP_READ && sel_ok) n_out_data[316:285] = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
            r_out_user <= bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    always_comb begin
        o_sts.clr_done  = r_caddr == AW'(DEPTH - 1);
        o_sts.div_done  = r_dcnt == '0;
        o_sts.med_stop  = med_hit || (r_bidx == nb_m1);
        o_sts.bad_label = bad;
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.op        = r_op;
    end

endmodule

### rtl/core/latency_histogram_profiler.sv
// Top level of the latency histogram profiler.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------------
//  s        | in        | tvalid / tready      | tuser opcode, tdata label/time/select
//  m        | out       | tvalid / tready      | tuser status, tdata results
//  cfg      | in        | valid / ready        | index, data (width, bucket count)
//
// An end runs the restoring divider, one quotient bit per cycle; a median query
// walks the buckets through the single read port of the bucket memory.
// After reset a clearing sweep writes LABELS * BUCKETS entries, one per cycle,
// with s_tready low; configuration is taken at any time.
// A held result waits in the output register; the block finishes the next item
// up to the point of delivery while it waits.
module latency_histogram_profiler #(
    parameter int LABELS    = 16,
    parameter int BUCKETS   = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [1:0]                      i_s_tuser,  // opcode[1:0]
    input  logic [lhp_pkg::IN_DATA_W-1:0]   i_s_tdata,  // label[4:0], time_ns[52:5],
                                                        // bucket_select[58:53]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic                            o_m_tuser,  // status[0]
    output logic [lhp_pkg::OUT_DATA_W-1:0]  o_m_tdata,  // duration[47:0],
        // bucket_hit[53:48], overflowed[54], sample_count[86:55],
        // sample_sum[150:87], min_sample[198:151], max_sample[246:199],
        // overflow_count[278:247], median_bucket[284:279], bucket_value[316:285]
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    lhp_pkg::t_cmd cmd;
    lhp_pkg::t_sts sts;
    logic          ready;

    assign o_s_tready  = ready;
    assign o_cfg_ready = 1'b1;

    lhp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_tvalid && ready),
        .i_sts    (sts),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    lhp_dp #(
        .LABELS    (LABELS),
        .BUCKETS   (BUCKETS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (i_s_tuser),
        .i_in_data   (i_s_tdata),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_user  (o_m_tuser),
        .o_out_data  (o_m_tdata)
    );

endmodule
